/* rtl/assert_macros.svh */
// Assertion helpers for the allocator checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off during reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/ffha_pkg.sv */
package ffha_pkg;

  localparam int unsigned MinBlockUnits = 2;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic CfgHeapBase  = 1'b0;
  localparam logic CfgHeapBytes = 1'b1;

  typedef struct packed {
    logic        op;
    logic [14:0] request_bytes;
    logic [31:0] release_address;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] payload_address;
    logic [14:0] total_bytes;
    logic [14:0] free_bytes;
  } rsp_t;

  typedef enum logic [4:0] {
    StInit,
    StInit2,
    StIdle,
    StAChk,
    StARdNext,
    StAWaitSz,
    StATest,
    StAWrite,
    StAWrite2,
    StFChk,
    StFRdSz,
    StFWaitSz,
    StFTest,
    StFWalkRd,
    StFWalkWt,
    StFWalkT,
    StFNxtRd,
    StFNxtWt,
    StFMergeN,
    StFPrvRd,
    StFPrvWt,
    StFMergeP,
    StDone
  } state_e;

endpackage

/* rtl/first_fit_heap_allocator_unit.sv */
// First-fit circular free-list allocator over a store of HEAP_UNITS+1 headers.
// An allocate walks the free list from the rover, reading the link and size of each free block
// visited; a free checks the address, walks the address-ordered list and merges neighbours.
// Requests rejected up front go straight to the result; a new beat is taken only in the idle
// state after each result beat. Reset and every configuration write set up the heap
// as at most one free block; no clearing pass runs, unwritten headers are never read by valid use.
module first_fit_heap_allocator_unit #(
  parameter int unsigned HEAP_UNITS = 1024,
  parameter int unsigned UNIT_BYTES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ffha_pkg::req_t       in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ffha_pkg::rsp_t       out_data_o
);

  localparam int unsigned IW = $clog2(HEAP_UNITS + 1) + 1;
  localparam int unsigned UB = $clog2(UNIT_BYTES);
  localparam int unsigned Depth = HEAP_UNITS + 1;
  localparam logic [IW-1:0] LastIdx = IW'(HEAP_UNITS);
  localparam logic [IW+1:0] WalkLimit = (IW+2)'(HEAP_UNITS + 2);

  logic [IW-1:0] link_mem [Depth];
  logic [IW-1:0] size_mem [Depth];

  ffha_pkg::state_e st_q, st_d;
  logic [31:0] base_q;
  logic [14:0] hbytes_q;
  logic [IW-1:0] total_q, total_d;
  logic [31:0] freeb_q, freeb_d;
  logic [IW-1:0] rover_q, rover_d;
  logic [IW-1:0] prev_q, prev_d, cur_q, cur_d, nxt_q, nxt_d;
  logic [IW-1:0] b_q, b_d, need_q, need_d, bsz_q, bsz_d, csz_q, csz_d;
  logic [IW+1:0] cnt_q, cnt_d;
  logic [31:0] addr_q, addr_d;
  logic ok_q, ok_d, op_q, op_d;
  logic [14:0] reqb_q, reqb_d;
  logic [31:0] rel_q, rel_d;

  // Single shared store port: one read address, one write each for size and link.
  logic [IW-1:0] ra;
  logic [IW-1:0] rd_link_q, rd_size_q;
  logic          lwe, swe;
  logic [IW-1:0] lwa, lwd, swa, swd;
  logic          rvalid;

  // Shared adder used by the size checks and merges.
  logic [IW:0] add_a, add_b, add_s;
  assign add_s = add_a + add_b;

  always_ff @(posedge clk_i) begin
    if (lwe && lwa <= LastIdx) link_mem[lwa[IW-2:0]] <= lwd;
    if (swe && swa <= LastIdx) size_mem[swa[IW-2:0]] <= swd;
    rvalid <= ra <= LastIdx;
    rd_link_q <= link_mem[ra[IW-2:0]];
    rd_size_q <= size_mem[ra[IW-2:0]];
  end

  logic [IW-1:0] rl, rs;
  assign rl = rvalid ? rd_link_q : '0;
  assign rs = rvalid ? rd_size_q : '0;

  logic [IW-1:0] cfg_units;
  always_comb begin
    if (32'(hbytes_q[14:UB]) > 32'(HEAP_UNITS)) cfg_units = LastIdx;
    else cfg_units = IW'(hbytes_q[14:UB]);
    if (cfg_units < IW'(ffha_pkg::MinBlockUnits)) cfg_units = '0;
  end

  logic [31:0] off;
  logic [14:0] req_units;
  assign off = rel_q - base_q;
  assign req_units = 15'((16'(reqb_q) + 16'(UNIT_BYTES - 1)) >> UB);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ffha_pkg::StInit;
      base_q <= '0;
      hbytes_q <= 15'd16384;
      total_q <= '0;
      freeb_q <= '0;
      rover_q <= '0;
      cnt_q <= '0;
      ok_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ffha_pkg::CfgHeapBase:  base_q <= cfg_data_i;
          ffha_pkg::CfgHeapBytes: hbytes_q <= cfg_data_i[14:0];
          default: ;
        endcase
        st_q <= ffha_pkg::StInit;
      end else begin
        st_q <= st_d;
      end
      total_q <= total_d;
      freeb_q <= freeb_d;
      rover_q <= rover_d;
      cnt_q <= cnt_d;
      ok_q <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d; cur_q <= cur_d; nxt_q <= nxt_d; b_q <= b_d;
    need_q <= need_d; bsz_q <= bsz_d; csz_q <= csz_d; addr_q <= addr_d;
    op_q <= op_d; reqb_q <= reqb_d; rel_q <= rel_d;
  end

  logic [31:0] ub_total;
  assign ub_total = 32'(total_q) << UB;

  always_comb begin
    st_d = st_q;
    total_d = total_q; freeb_d = freeb_q; rover_d = rover_q;
    prev_d = prev_q; cur_d = cur_q; nxt_d = nxt_q; b_d = b_q;
    need_d = need_q; bsz_d = bsz_q; csz_d = csz_q; cnt_d = cnt_q;
    addr_d = addr_q; ok_d = ok_q; op_d = op_q; reqb_d = reqb_q; rel_d = rel_q;
    ra = '0; lwe = 1'b0; swe = 1'b0; lwa = '0; lwd = '0; swa = '0; swd = '0;
    add_a = '0; add_b = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (st_q)
      ffha_pkg::StInit: begin
        total_d = cfg_units;
        freeb_d = 32'(cfg_units) << UB;
        rover_d = '0;
        lwe = cfg_units != '0; lwa = '0; lwd = IW'(1);
        swe = cfg_units != '0; swa = IW'(1); swd = cfg_units;
        st_d = ffha_pkg::StInit2;
      end
      // The sentinel has size zero and the single free block links back to it.
      ffha_pkg::StInit2: begin
        lwe = 1'b1; lwa = IW'(1); lwd = '0;
        swe = 1'b1; swa = '0; swd = '0;
        st_d = ffha_pkg::StIdle;
      end
      ffha_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d = in_data_i.op;
          reqb_d = in_data_i.request_bytes;
          rel_d = in_data_i.release_address;
          ok_d = 1'b0; addr_d = '0; cnt_d = '0;
          st_d = in_data_i.op == ffha_pkg::OpFree ? ffha_pkg::StFChk : ffha_pkg::StAChk;
        end
      end
      // ---------------- allocate ----------------
      ffha_pkg::StAChk: begin
        add_a = (IW+1)'(req_units); add_b = (IW+1)'(1);
        if (add_s < (IW+1)'(ffha_pkg::MinBlockUnits)) need_d = IW'(ffha_pkg::MinBlockUnits);
        else need_d = add_s[IW-1:0];
        prev_d = rover_q;
        ra = rover_q;
        if (reqb_q == '0 || req_units >= 15'(total_q)) st_d = ffha_pkg::StDone;
        else st_d = ffha_pkg::StARdNext;
      end
      ffha_pkg::StARdNext: begin
        cur_d = rl;
        ra = rl;
        st_d = ffha_pkg::StAWaitSz;
      end
      ffha_pkg::StAWaitSz: begin
        csz_d = rs; nxt_d = rl;
        st_d = ffha_pkg::StATest;
      end
      ffha_pkg::StATest: begin
        add_a = (IW+1)'(cur_q); add_b = (IW+1)'(csz_q - need_q);
        if (cnt_q >= WalkLimit) st_d = ffha_pkg::StDone;
        else if (csz_q >= need_q) begin
          if (csz_q == need_q) begin
            lwe = 1'b1; lwa = prev_q; lwd = nxt_q;
            b_d = cur_q;
            st_d = ffha_pkg::StAWrite2;
          end else if (add_s > (IW+1)'(LastIdx)) begin
            st_d = ffha_pkg::StDone;
          end else begin
            b_d = add_s[IW-1:0];
            swe = 1'b1; swa = cur_q; swd = csz_q - need_q;
            st_d = ffha_pkg::StAWrite;
          end
        end else if (cur_q == rover_q) begin
          st_d = ffha_pkg::StDone;
        end else begin
          prev_d = cur_q;
          cnt_d = cnt_q + 1'b1;
          ra = cur_q;
          st_d = ffha_pkg::StARdNext;
        end
      end
      ffha_pkg::StAWrite: begin
        swe = 1'b1; swa = b_q; swd = need_q;
        st_d = ffha_pkg::StAWrite2;
      end
      ffha_pkg::StAWrite2: begin
        rover_d = prev_q;
        freeb_d = freeb_q >= (32'(need_q) << UB) ? freeb_q - (32'(need_q) << UB) : '0;
        addr_d = base_q + (32'(b_q) << UB);
        ok_d = 1'b1;
        st_d = ffha_pkg::StDone;
      end
      // ---------------- free ----------------
      ffha_pkg::StFChk: begin
        b_d = off[IW+UB-1:UB];
        if (rel_q == '0 || off < 32'(UNIT_BYTES) || off[UB-1:0] != '0 ||
            off[31:UB] > (32-UB)'(total_q)) st_d = ffha_pkg::StDone;
        else st_d = ffha_pkg::StFRdSz;
      end
      ffha_pkg::StFRdSz: begin
        ra = b_q;
        st_d = ffha_pkg::StFWaitSz;
      end
      ffha_pkg::StFWaitSz: begin
        bsz_d = rs;
        st_d = ffha_pkg::StFTest;
      end
      ffha_pkg::StFTest: begin
        add_a = (IW+1)'(total_q) + 1'b1; add_b = '0;
        if (bsz_q == '0 || (IW+1)'(bsz_q) > add_s - (IW+1)'(b_q)) begin
          st_d = ffha_pkg::StDone;
        end else begin
          freeb_d = (freeb_q + (32'(bsz_q) << UB)) > ub_total ? ub_total
                    : freeb_q + (32'(bsz_q) << UB);
          cur_d = rover_q;
          st_d = ffha_pkg::StFWalkRd;
        end
      end
      ffha_pkg::StFWalkRd: begin
        ra = cur_q;
        st_d = ffha_pkg::StFWalkWt;
      end
      ffha_pkg::StFWalkWt: begin
        nxt_d = rl;
        st_d = ffha_pkg::StFWalkT;
      end
      ffha_pkg::StFWalkT: begin
        if (cnt_q >= WalkLimit ||
            (b_q > cur_q && b_q < nxt_q) ||
            (cur_q >= nxt_q && (b_q > cur_q || b_q < nxt_q))) begin
          st_d = ffha_pkg::StFNxtRd;
        end else begin
          cur_d = nxt_q;
          cnt_d = cnt_q + 1'b1;
          st_d = ffha_pkg::StFWalkRd;
        end
      end
      ffha_pkg::StFNxtRd: begin
        ra = nxt_q;
        st_d = ffha_pkg::StFNxtWt;
      end
      ffha_pkg::StFNxtWt: begin
        csz_d = rs; prev_d = rl;
        st_d = ffha_pkg::StFMergeN;
      end
      ffha_pkg::StFMergeN: begin
        add_a = (IW+1)'(b_q); add_b = (IW+1)'(bsz_q);
        lwe = 1'b1; lwa = b_q;
        if (add_s == (IW+1)'(nxt_q)) begin
          bsz_d = bsz_q + csz_q;
          swe = 1'b1; swa = b_q; swd = bsz_q + csz_q;
          lwd = prev_q;
          nxt_d = prev_q;
        end else begin
          lwd = nxt_q;
        end
        st_d = ffha_pkg::StFPrvRd;
      end
      ffha_pkg::StFPrvRd: begin
        ra = cur_q;
        st_d = ffha_pkg::StFPrvWt;
      end
      ffha_pkg::StFPrvWt: begin
        csz_d = rs;
        st_d = ffha_pkg::StFMergeP;
      end
      ffha_pkg::StFMergeP: begin
        add_a = (IW+1)'(cur_q); add_b = (IW+1)'(csz_q);
        lwe = 1'b1; lwa = cur_q;
        if (add_s == (IW+1)'(b_q)) begin
          swe = 1'b1; swa = cur_q; swd = csz_q + bsz_q;
          lwd = nxt_q;
          rover_d = cur_q;
        end else begin
          lwd = b_q;
          rover_d = b_q;
        end
        ok_d = 1'b1;
        st_d = ffha_pkg::StDone;
      end
      ffha_pkg::StDone: begin
        out_valid_o = 1'b1;
        if (out_ready_i) st_d = ffha_pkg::StIdle;
      end
      default: st_d = ffha_pkg::StInit;
    endcase
  end

  always_comb begin
    out_data_o.ok = ok_q;
    out_data_o.payload_address = ok_q && op_q == ffha_pkg::OpAlloc ? addr_q : '0;
    out_data_o.total_bytes = ub_total[14:0];
    out_data_o.free_bytes = freeb_q[14:0];
  end

endmodule

/* rtl/ffha_checker.sv */
`include "assert_macros.svh"

module ffha_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input ffha_pkg::req_t in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input ffha_pkg::rsp_t out_data_o
);

  // One request at a time: no new beat while a result is pending.
  `ASSERT_IMPL(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)
  // A failed result never carries an address.
  `ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, out_valid_o && !out_data_o.ok, out_data_o.payload_address == '0)
  // Free bytes never exceed the managed total.
  `ASSERT_IMPL(a_free_le, clk_i, rst_ni, out_valid_o, out_data_o.free_bytes <= out_data_o.total_bytes)
  // A stalled result holds.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (.*);

/* sim/tb.sv */
module tb;

  localparam int unsigned NUnits = 1024;
  localparam int unsigned UnitB = 16;
  localparam int unsigned WalkMax = NUnits + 2;

  logic           clk;
  logic           rst_n;
  logic           cfg_we;
  logic           cfg_index;
  logic [31:0]    cfg_data;
  logic           in_valid;
  logic           in_ready;
  ffha_pkg::req_t in_data;
  logic           out_valid;
  logic           out_ready;
  ffha_pkg::rsp_t out_data;

  first_fit_heap_allocator_unit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  // Shadow of the allocator state used to predict each response.
  logic [31:0] sh_base;
  logic [14:0] sh_bytes;
  int unsigned sh_link [NUnits + 1];
  int unsigned sh_size [NUnits + 1];
  int unsigned sh_rover;
  int unsigned sh_free;
  int unsigned sh_units;

  ffha_pkg::req_t pending_reqs[$];
  ffha_pkg::rsp_t expected_rsps[$];
  logic [31:0]    live_blocks[$];
  int             n_errors;
  int             n_sent;
  bit             in_quiet;
  bit             out_quiet;

  function automatic int unsigned lk(int unsigned i);
    return (i <= NUnits) ? sh_link[i] : 0;
  endfunction

  function automatic int unsigned sz(int unsigned i);
    return (i <= NUnits) ? sh_size[i] : 0;
  endfunction

  function automatic void set_lk(int unsigned i, int unsigned v);
    if (i <= NUnits) sh_link[i] = v;
  endfunction

  function automatic void set_sz(int unsigned i, int unsigned v);
    if (i <= NUnits) sh_size[i] = v;
  endfunction

  function automatic void heap_setup();
    foreach (sh_link[i]) begin
      sh_link[i] = 0;
      sh_size[i] = 0;
    end
    sh_units = sh_bytes / UnitB;
    if (sh_units > NUnits) sh_units = NUnits;
    sh_rover = 0;
    if (sh_units < ffha_pkg::MinBlockUnits) begin
      sh_units = 0;
      sh_free = 0;
    end else begin
      sh_size[1] = sh_units;
      sh_link[1] = 0;
      sh_link[0] = 1;
      sh_free = sh_units * UnitB;
    end
  endfunction

  function automatic bit carve_block(int unsigned req, output logic [31:0] addr);
    int unsigned need, prev, cur, s, blk;
    addr = 0;
    if (req == 0) return 0;
    need = (req + UnitB - 1) / UnitB + 1;
    if (need < ffha_pkg::MinBlockUnits) need = ffha_pkg::MinBlockUnits;
    if (need > sh_units) return 0;
    prev = sh_rover;
    cur = lk(prev);
    for (int n = 0; n < WalkMax; n++) begin
      s = sz(cur);
      if (s >= need) begin
        if (s == need) begin
          set_lk(prev, lk(cur));
          blk = cur;
        end else begin
          blk = cur + s - need;
          if (blk > NUnits) return 0;
          set_sz(cur, s - need);
          set_sz(blk, need);
        end
        sh_rover = prev;
        sh_free = (sh_free >= need * UnitB) ? sh_free - need * UnitB : 0;
        addr = sh_base + blk * UnitB;
        return 1;
      end
      if (cur == sh_rover) return 0;
      prev = cur;
      cur = lk(cur);
    end
    return 0;
  endfunction

  function automatic bit release_block(logic [31:0] addr);
    logic [31:0] off;
    int unsigned b, s, cur, nxt, total;
    if (addr == 0) return 0;
    off = addr - sh_base;
    if (off < UnitB || off % UnitB != 0) return 0;
    if (off / UnitB > sh_units) return 0;
    b = off / UnitB;
    s = sz(b);
    if (s == 0 || s > sh_units + 1 - b) return 0;
    total = sh_units * UnitB;
    sh_free += s * UnitB;
    if (sh_free > total) sh_free = total;
    cur = sh_rover;
    for (int n = 0; n < WalkMax; n++) begin
      nxt = lk(cur);
      if (b > cur && b < nxt) break;
      if (cur >= nxt && (b > cur || b < nxt)) break;
      cur = nxt;
    end
    nxt = lk(cur);
    if (b + sz(b) == nxt) begin
      set_sz(b, sz(b) + sz(nxt));
      set_lk(b, lk(nxt));
    end else begin
      set_lk(b, nxt);
    end
    if (cur + sz(cur) == b) begin
      set_sz(cur, sz(cur) + sz(b));
      set_lk(cur, lk(b));
    end else begin
      set_lk(cur, b);
      cur = b;
    end
    sh_rover = cur;
    return 1;
  endfunction

  function automatic ffha_pkg::rsp_t predict_rsp(ffha_pkg::req_t r);
    ffha_pkg::rsp_t p;
    logic [31:0]    a;
    bit             good;
    a = 0;
    if (r.op == ffha_pkg::OpAlloc) good = carve_block(r.request_bytes, a);
    else good = release_block(r.release_address);
    if (!good) a = 0;
    p.ok = good;
    p.payload_address = a;
    p.total_bytes = 15'(sh_units * UnitB);
    p.free_bytes = 15'(sh_free);
    return p;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    n_errors++;
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Driver: the shadow model advances when a beat is accepted.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(predict_rsp(in_data));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && !(in_quiet && $urandom_range(99) < 8)) begin
          in_valid <= 1;
          in_data <= pending_reqs.pop_front();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          ffha_pkg::rsp_t e;
          e = expected_rsps.pop_front();
          if (out_data.ok !== e.ok) report("ok", out_data.ok, e.ok);
          if (out_data.payload_address !== e.payload_address)
            report("payload_address", out_data.payload_address, e.payload_address);
          if (out_data.total_bytes !== e.total_bytes)
            report("total_bytes", out_data.total_bytes, e.total_bytes);
          if (out_data.free_bytes !== e.free_bytes)
            report("free_bytes", out_data.free_bytes, e.free_bytes);
          if (e.ok && e.payload_address != 0 && out_data.payload_address == e.payload_address
              && $urandom_range(3) != 0)
            live_blocks.push_back(e.payload_address);
        end
      end
      out_ready <= !(out_quiet && $urandom_range(99) < 8);
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == ffha_pkg::CfgHeapBase) sh_base = val;
    else sh_bytes = val[14:0];
    heap_setup();
    live_blocks.delete();
    @(posedge clk);
  endtask

  task automatic add_alloc(int unsigned n);
    ffha_pkg::req_t r;
    r.op = ffha_pkg::OpAlloc;
    r.request_bytes = 15'(n);
    r.release_address = 32'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic add_free(logic [31:0] a);
    ffha_pkg::req_t r;
    r.op = ffha_pkg::OpFree;
    r.request_bytes = 15'($urandom);
    r.release_address = a;
    pending_reqs.push_back(r);
  endtask

  // Random phase: mostly frees of live blocks and modest allocations.
  task automatic random_phase(int unsigned count);
    int unsigned k, pick;
    for (int i = 0; i < count; i++) begin
      // Feed one item at a time so freed addresses come from real results.
      while (pending_reqs.size() > 0) @(posedge clk);
      k = $urandom_range(99);
      if (k < 40 && live_blocks.size() > 0) begin
        pick = $urandom_range(live_blocks.size() - 1);
        add_free(live_blocks[pick]);
        live_blocks.delete(pick);
      end else if (k < 85) begin
        add_alloc($urandom_range(400));
      end else if (k < 90) begin
        add_alloc($urandom_range(32767));
      end else if (k < 95) begin
        add_free(0);
      end else begin
        // Outside the heap or misaligned, so no unwritten header is read.
        add_free(sh_base + (sh_units + 1 + $urandom_range(50)) * UnitB + $urandom_range(1) * 3);
      end
      // Let the response land before the next free picks from the live list.
      while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0) @(posedge clk);
    end
  endtask

  initial begin
    n_errors = 0;
    n_sent = 0;
    in_quiet = 0;
    out_quiet = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = ffha_pkg::CfgHeapBase;
    cfg_data = 0;
    sh_base = 0;
    sh_bytes = 15'd16384;
    heap_setup();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes of the request, null and foreign frees.
    add_alloc(0);
    add_alloc(1);
    add_alloc(16);
    add_alloc(17);
    add_alloc(16368);
    add_alloc(16384);
    add_alloc(32767);
    add_free(0);
    add_free(32'hFFFF_FFF0);
    add_free(32'h0000_0008);
    add_alloc(16336);
    add_alloc(16);
    wait_drained();
    // Free the pieces recorded as live so far so that merging on both sides is exercised.
    while (live_blocks.size() > 0) add_free(live_blocks.pop_back());
    add_alloc(16368);
    add_alloc(1);
    wait_drained();

    // Tiny heap, base extreme and odd sizes.
    write_reg(ffha_pkg::CfgHeapBytes, 32'd16);
    add_alloc(1);
    add_free(32'h10);
    wait_drained();
    write_reg(ffha_pkg::CfgHeapBytes, 32'd0);
    add_alloc(1);
    wait_drained();
    write_reg(ffha_pkg::CfgHeapBase, 32'hFFFF_F000);
    write_reg(ffha_pkg::CfgHeapBytes, 32'd40);
    add_alloc(1);
    add_alloc(1);
    wait_drained();

    in_quiet = 1;
    out_quiet = 1;
    write_reg(ffha_pkg::CfgHeapBytes, 32'd32767);
    random_phase(150);
    wait_drained();
    write_reg(ffha_pkg::CfgHeapBase, 32'h1234_5670);
    write_reg(ffha_pkg::CfgHeapBytes, 32'd2000);
    random_phase(100);
    wait_drained();
    in_quiet = 0;
    out_quiet = 0;
    write_reg(ffha_pkg::CfgHeapBase, 32'hFFFF_FFFF);
    write_reg(ffha_pkg::CfgHeapBytes, 32'd16384);
    random_phase(150);

    wait_drained();
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ffha_pkg.sv
rtl/first_fit_heap_allocator_unit.sv
rtl/ffha_checker.sv
sim/tb.sv
